@@ rtl/iplpm_pkg.sv @@
// ============================================================================
// IPv4 LPM table package
// Types, command and status codes, and the prefix mask function shared by the
// prefix table modules.
// ============================================================================
package iplpm_pkg;

    // Default table depth.
    localparam int ENTRIES_DEF = 64;

    // Command codes.
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CHECK  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EXISTS   = 3'd1;
    localparam logic [2:0] ST_ABSENT   = 3'd2;
    localparam logic [2:0] ST_BAD_LEN  = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    // Longest legal prefix length and the no-match code of match_len.
    localparam logic [5:0] MAX_LEN  = 6'd32;
    localparam logic [6:0] NO_MATCH = 7'h7F;

    // One table slot as stored in memory.
    typedef struct packed {
        logic        valid;
        logic [5:0]  length;
        logic [31:0] base;
    } entry_t;

    // Per-slot verdict of the compare unit.
    typedef struct packed {
        logic exact;   // slot holds exactly the requested prefix
        logic free;    // slot is empty
        logic better;  // slot covers the address and beats the best so far
    } cmp_res_t;

    // Network mask with the top len bits set; lengths of 32 and above give
    // all ones.
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        len_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

@@ rtl/iplpm_ram.sv @@
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module iplpm_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = iplpm_pkg::ENTRIES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/iplpm_cmp.sv @@
// ============================================================================
// Prefix compare unit
// Judges one table slot against the current command: exact prefix hit, free
// slot, and longer covering prefix for a lookup.
// ============================================================================
module iplpm_cmp (
    input  iplpm_pkg::entry_t   entry,
    input  logic [31:0]         address,
    input  logic [5:0]          prefix_len,
    input  logic                best_valid,
    input  logic [5:0]          best_len,
    output iplpm_pkg::cmp_res_t res
);

    logic covers;

    // The slot covers the address when the address masked to the slot length
    // equals the stored base.
    assign covers = entry.valid && (entry.length <= iplpm_pkg::MAX_LEN) &&
                    ((address & iplpm_pkg::len_mask(entry.length)) == entry.base);

    assign res.exact  = entry.valid && (entry.base == address) &&
                        (entry.length == prefix_len);
    assign res.free   = !entry.valid;
    assign res.better = covers && (!best_valid || (entry.length > best_len));

endmodule

@@ rtl/ipv4_prefix_table_lpm_top.sv @@
// ============================================================================
// IPv4 prefix table with longest-prefix match
// Stores up to ENTRIES prefixes and serves add, remove and lookup commands.
// ============================================================================
// After reset the block runs a clearing pass over every slot of the table
// memory, holding in_stall high. Before the result word of a lookup or of a
// valid add or remove is loaded into the output register, every slot is
// read once through the single read port of the table memory and judged
// by one shared compare unit, one slot per cycle. An add or remove that
// fails validation, and command 3, skip the table scan and go straight to
// forming the result. The block accepts one word at a time; a finished result
// waiting in the output register does not hold off the next input word.
module ipv4_prefix_table_lpm_top #(
    parameter int ENTRIES = iplpm_pkg::ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic [31:0]       address,
    input  logic [5:0]        prefix_len,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic signed [6:0] match_len
);

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int ENTRY_W = $bits(iplpm_pkg::entry_t);

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(ENTRIES);

    // Sequencer states.
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic [1:0]       cmd_reg, cmd_next;
    logic [31:0]      addr_reg, addr_next;
    logic [5:0]       len_reg, len_next;
    logic [2:0]       vstat_reg, vstat_next;

    logic             found_reg, found_next;
    logic [IDX_W-1:0] found_idx_reg, found_idx_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             best_valid_reg, best_valid_next;
    logic [5:0]       best_len_reg, best_len_next;

    logic             out_valid_reg, out_valid_next;
    logic [2:0]       status_reg, status_next;
    logic [6:0]       match_reg, match_next;

    logic               accept;
    logic               out_free;
    logic [2:0]         vstat_in;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    iplpm_pkg::entry_t  wr_entry;
    logic               rd_en;
    logic [ENTRY_W-1:0] rd_data;
    iplpm_pkg::entry_t  rd_entry;
    iplpm_pkg::cmp_res_t cmp_res;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_entry = iplpm_pkg::entry_t'(rd_data);

    // Prefix validation of the incoming word.
    always_comb
    begin
        if (prefix_len > iplpm_pkg::MAX_LEN)
        begin
            vstat_in = iplpm_pkg::ST_BAD_LEN;
        end
        else if ((address & ~iplpm_pkg::len_mask(prefix_len)) != 32'd0)
        begin
            vstat_in = iplpm_pkg::ST_MISMATCH;
        end
        else
        begin
            vstat_in = iplpm_pkg::ST_OK;
        end
    end

    // Table memory.
    iplpm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_entry),
        .rd_en  (rd_en),
        .rd_addr(cnt_reg[IDX_W-1:0]),
        .rd_data(rd_data)
    );

    // Shared compare unit, fed one slot per cycle.
    iplpm_cmp u_cmp (
        .entry     (rd_entry),
        .address   (addr_reg),
        .prefix_len(len_reg),
        .best_valid(best_valid_reg),
        .best_len  (best_len_reg),
        .res       (cmp_res)
    );

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        idx_next        = idx_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        vstat_next      = vstat_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        best_valid_next = best_valid_reg;
        best_len_next   = best_len_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        match_next      = match_reg;
        wr_en           = 1'b0;
        wr_addr         = cnt_reg[IDX_W-1:0];
        wr_entry        = '0;
        rd_en           = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                // Empty one slot per cycle after reset.
                wr_en = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = command;
                    addr_next       = address;
                    len_next        = prefix_len;
                    vstat_next      = vstat_in;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    free_next       = 1'b0;
                    best_valid_next = 1'b0;
                    if ((command == iplpm_pkg::CMD_NONE) ||
                        ((command inside {iplpm_pkg::CMD_ADD, iplpm_pkg::CMD_REMOVE}) &&
                         (vstat_in != iplpm_pkg::ST_OK)))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next slot read.
                if (cnt_reg < CNT_DEPTH)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = cnt_reg[IDX_W-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end
                // Judge the slot read in the previous cycle.
                if (pend_reg)
                begin
                    if (cmp_res.exact && !found_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = idx_reg;
                    end
                    if (cmp_res.free && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    if (cmp_res.better)
                    begin
                        best_valid_next = 1'b1;
                        best_len_next   = rd_entry.length;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                // Form the result and commit any table update with it.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    match_next     = iplpm_pkg::NO_MATCH;
                    state_next     = S_IDLE;
                    if (cmd_reg == iplpm_pkg::CMD_CHECK)
                    begin
                        status_next = iplpm_pkg::ST_OK;
                        if (best_valid_reg)
                        begin
                            match_next = {1'b0, best_len_reg};
                        end
                    end
                    else if (cmd_reg == iplpm_pkg::CMD_NONE)
                    begin
                        status_next = iplpm_pkg::ST_OK;
                    end
                    else if (vstat_reg != iplpm_pkg::ST_OK)
                    begin
                        status_next = vstat_reg;
                    end
                    else if (cmd_reg == iplpm_pkg::CMD_ADD)
                    begin
                        if (found_reg)
                        begin
                            status_next = iplpm_pkg::ST_EXISTS;
                        end
                        else if (free_reg)
                        begin
                            status_next     = iplpm_pkg::ST_OK;
                            wr_en           = 1'b1;
                            wr_addr         = free_idx_reg;
                            wr_entry.valid  = 1'b1;
                            wr_entry.length = len_reg;
                            wr_entry.base   = addr_reg;
                        end
                        else
                        begin
                            status_next = iplpm_pkg::ST_FULL;
                        end
                    end
                    else
                    begin
                        if (found_reg)
                        begin
                            status_next = iplpm_pkg::ST_OK;
                            wr_en       = 1'b1;
                            wr_addr     = found_idx_reg;
                        end
                        else
                        begin
                            status_next = iplpm_pkg::ST_ABSENT;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and scan bookkeeping registers.
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        cmd_reg        <= cmd_next;
        addr_reg       <= addr_next;
        len_reg        <= len_next;
        vstat_reg      <= vstat_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        free_reg       <= free_next;
        free_idx_reg   <= free_idx_next;
        best_valid_reg <= best_valid_next;
        best_len_reg   <= best_len_next;
        status_reg     <= status_next;
        match_reg      <= match_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign match_len = signed'(match_reg);

endmodule
